@@ hw/rtl/mme_pkg.sv @@
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, widths and codes of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

	// Field widths of one item
	localparam int OPCODE_W = 2;
	localparam int ROW_W    = 3;
	localparam int COL_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int DIM_W    = 4;

	// Default largest matrix dimension
	localparam int MAX_DIM_DEF = 8;

	// Command queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;

	// Arithmetic: full product, accumulator with headroom for eight terms
	localparam int PROD_W = 2 * VALUE_W;
	localparam int ACC_W  = PROD_W + 3;
	localparam int FRAC_W = 16;

	// Input opcodes
	localparam logic [OPCODE_W-1:0] OP_WRITE_A = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_WRITE_B = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_COMPUTE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_A_ROWS = 2'd0;
	localparam logic [1:0] REG_A_COLS = 2'd1;
	localparam logic [1:0] REG_B_ROWS = 2'd2;
	localparam logic [1:0] REG_B_COLS = 2'd3;

	// Result status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef enum logic [1:0] {
		CMD_WRITE_A,
		CMD_WRITE_B,
		CMD_COMPUTE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
		logic [VALUE_W-1:0]  value;
		logic                status;
	} cmd_t;

	typedef struct packed {
		logic [DIM_W-1:0] a_rows;
		logic [DIM_W-1:0] a_cols;
		logic [DIM_W-1:0] b_rows;
		logic [DIM_W-1:0] b_cols;
	} dims_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} back_state_t;

	// A dimension of zero acts as one, any value above the maximum acts as the maximum.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
			input int max_dim);
		logic [DIM_W-1:0] res;
		res = r;
		if (r == '0) begin
			res = DIM_W'(1);
		end else if (int'(r) > max_dim) begin
			res = DIM_W'(max_dim);
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/mme_ram.sv @@
// ----------------------------------------------------------------------------
// mme_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/mme_front.sv @@
// ----------------------------------------------------------------------------
// mme_front
// Accepts input items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module mme_front
	import mme_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OPCODE_W-1:0] in_opcode,
	input  logic [ROW_W-1:0]    in_row,
	input  logic [COL_W-1:0]    in_col,
	input  logic [VALUE_W-1:0]  in_value,
	input  dims_t               dims,
	output logic                cmd_valid,
	output cmd_t                cmd,
	input  logic                cmd_pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	cmd_t             new_cmd;
	logic             keep;
	logic             push;

	// Decode the opcode and check write indexes against the dimensions.
	always_comb begin
		new_cmd.row    = in_row;
		new_cmd.col    = in_col;
		new_cmd.value  = in_value;
		new_cmd.kind   = CMD_COMPUTE;
		new_cmd.status = STATUS_OK;
		keep           = 1'b1;
		case (in_opcode)
			OP_WRITE_A: begin
				new_cmd.kind = CMD_WRITE_A;
				if (DIM_W'(in_row) >= dims.a_rows || DIM_W'(in_col) >= dims.a_cols) begin
					new_cmd.status = STATUS_RANGE;
				end
			end
			OP_WRITE_B: begin
				new_cmd.kind = CMD_WRITE_B;
				if (DIM_W'(in_row) >= dims.b_rows || DIM_W'(in_col) >= dims.b_cols) begin
					new_cmd.status = STATUS_RANGE;
				end
			end
			OP_COMPUTE: begin
				new_cmd.kind = CMD_COMPUTE;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready  = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push      = in_valid && in_ready && keep;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && cmd_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ hw/rtl/mme_back.sv @@
// ----------------------------------------------------------------------------
// mme_back
// Carries out queued commands: element writes and the product sweep, with
// a multiply-accumulate pipeline and the result register.
// ----------------------------------------------------------------------------
module mme_back
	import mme_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dims_t              dims,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ROW_W-1:0]   out_row,
	output logic [COL_W-1:0]   out_col,
	output logic [VALUE_W-1:0] out_value,
	output logic               out_status,
	output logic               out_last
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FLR_W  = ACC_W - FRAC_W;

	back_state_t state_q, state_d;
	logic [DIM_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [DIM_W-1:0] terms;
	logic             issue, last_issue, last_entry, emit;
	logic             we_a, we_b, load_out;
	logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
	logic [VALUE_W-1:0] rdata_a, rdata_b;

	logic [DEPTH-1:0] left_vld_q, right_vld_q;

	logic vld_s1, first_s1, last_s1, aval_s1, bval_s1;
	logic vld_s2, first_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     acc_done_q;
	logic signed [FLR_W-1:0]  floor_val;
	logic [VALUE_W-1:0]       sat_val;
	logic [VALUE_W-1:0]       op_a, op_b;

	logic [ROW_W-1:0]   ld_row;
	logic [COL_W-1:0]   ld_col;
	logic [VALUE_W-1:0] ld_value;
	logic               ld_status, ld_last;
	logic               out_free;

	assign out_free   = !out_valid || out_ready;
	assign terms      = (dims.a_cols < dims.b_rows) ? dims.a_cols : dims.b_rows;
	assign last_issue = (k_q == terms - DIM_W'(1));
	assign last_entry = (i_q == dims.a_rows - DIM_W'(1)) && (j_q == dims.b_cols - DIM_W'(1));

	assign waddr   = ADDR_W'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
	assign raddr_a = ADDR_W'(int'(i_q) * MAX_DIM + int'(k_q));
	assign raddr_b = ADDR_W'(int'(k_q) * MAX_DIM + int'(j_q));

	mme_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_left_ram (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (cmd.value),
		.re    (issue),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	mme_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_right_ram (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (cmd.value),
		.re    (issue),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// Floor to Q16.16 is an arithmetic shift; then clamp to 32 bits.
	always_comb begin
		floor_val = FLR_W'(acc_q >>> FRAC_W);
		if (floor_val[FLR_W-1:VALUE_W-1] == '0 || floor_val[FLR_W-1:VALUE_W-1] == '1) begin
			sat_val = floor_val[VALUE_W-1:0];
		end else if (floor_val[FLR_W-1]) begin
			sat_val = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(VALUE_W-1){1'b1}}};
		end
	end

	always_comb begin
		state_d   = state_q;
		i_d       = i_q;
		j_d       = j_q;
		k_d       = k_q;
		cmd_pop   = 1'b0;
		issue     = 1'b0;
		emit      = 1'b0;
		we_a      = 1'b0;
		we_b      = 1'b0;
		load_out  = 1'b0;
		ld_row    = cmd.row;
		ld_col    = cmd.col;
		ld_value  = '0;
		ld_status = cmd.status;
		ld_last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						CMD_WRITE_A, CMD_WRITE_B: begin
							if (out_free) begin
								cmd_pop  = 1'b1;
								load_out = 1'b1;
								we_a = (cmd.kind == CMD_WRITE_A) && (cmd.status == STATUS_OK);
								we_b = (cmd.kind == CMD_WRITE_B) && (cmd.status == STATUS_OK);
							end
						end
						CMD_COMPUTE: begin
							cmd_pop = 1'b1;
							i_d     = '0;
							j_d     = '0;
							k_d     = '0;
							state_d = ST_ISSUE;
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			ST_ISSUE: begin
				issue = 1'b1;
				if (last_issue) begin
					k_d     = '0;
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + DIM_W'(1);
				end
			end
			ST_DRAIN: begin
				if (acc_done_q && out_free) begin
					emit      = 1'b1;
					load_out  = 1'b1;
					ld_row    = i_q[ROW_W-1:0];
					ld_col    = j_q[COL_W-1:0];
					ld_value  = sat_val;
					ld_status = STATUS_OK;
					ld_last   = last_entry;
					if (last_entry) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_ISSUE;
						if (j_q == dims.b_cols - DIM_W'(1)) begin
							j_d = '0;
							i_d = i_q + DIM_W'(1);
						end else begin
							j_d = j_q + DIM_W'(1);
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Entries never written read as zero.
	assign op_a = aval_s1 ? rdata_a : '0;
	assign op_b = bval_s1 ? rdata_b : '0;

	always_ff @(posedge clk) begin
		aval_s1  <= left_vld_q[raddr_a];
		bval_s1  <= right_vld_q[raddr_b];
		first_s1 <= (k_q == '0);
		first_s2 <= first_s1;
		prod_s2  <= $signed(op_a) * $signed(op_b);
		if (vld_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) +
				{{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
		if (load_out) begin
			out_row    <= ld_row;
			out_col    <= ld_col;
			out_value  <= ld_value;
			out_status <= ld_status;
			out_last   <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			vld_s2      <= 1'b0;
			last_s2     <= 1'b0;
			acc_done_q  <= 1'b0;
			left_vld_q  <= '0;
			right_vld_q <= '0;
			out_valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			vld_s1  <= issue;
			last_s1 <= issue && last_issue;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			if (vld_s2 && last_s2) begin
				acc_done_q <= 1'b1;
			end else if (emit) begin
				acc_done_q <= 1'b0;
			end
			if (we_a) begin
				left_vld_q[waddr] <= 1'b1;
			end
			if (we_b) begin
				right_vld_q[waddr] <= 1'b1;
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/matrix_multiply_engine.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Signed Q16.16 matrix multiplier with element loads and a product sweep.
// ----------------------------------------------------------------------------
// Usage: program the four dimension registers over APB (a_rows, a_cols,
// b_rows, b_cols at byte addresses 0, 4, 8 and 12), then send items on the
// s_axis channel. tuser carries the opcode: write a left element, write a
// right element, or compute. Every write gives one acknowledgment item on
// m_axis with the written row and column, a zero value, tlast high, and
// tuser high when the index lies outside the configured dimensions (the
// store is then left alone). A compute command gives a_rows * b_cols items,
// row by row, with tlast on the final one.
// Element writes are taken and acknowledged one per cycle while m_axis does
// not stall. Each product entry makes one store read per term, terms being
// min(a_cols, b_rows), then the multiplier and accumulator stages drain.
// An item passes through the front queue, and its result through the
// result register, before the result is offered. Reset clears the
// dimension registers to one and marks every stored element as zero at
// once. When m_axis stalls, the back end holds its result and stops; the
// front queue keeps taking items until it fills.
// ----------------------------------------------------------------------------
module matrix_multiply_engine
	import mme_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // row[2:0], col[5:3], value[37:6], zero pad
	input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
	// Result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6], zero pad
	output logic [0:0]  m_axis_tuser,  // status[0]
	output logic        m_axis_tlast
);

	logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	dims_t            dims;
	logic             cfg_write;
	logic             cmd_valid, cmd_pop;
	cmd_t             cmd;
	logic [ROW_W-1:0]   res_row;
	logic [COL_W-1:0]   res_col;
	logic [VALUE_W-1:0] res_value;
	logic               res_status;

	// Configuration registers; writes land on the access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= DIM_W'(1);
			a_cols_q <= DIM_W'(1);
			b_rows_q <= DIM_W'(1);
			b_cols_q <= DIM_W'(1);
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_A_ROWS: a_rows_q <= pwdata[DIM_W-1:0];
				REG_A_COLS: a_cols_q <= pwdata[DIM_W-1:0];
				REG_B_ROWS: b_rows_q <= pwdata[DIM_W-1:0];
				REG_B_COLS: b_cols_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_A_ROWS: prdata = 32'(a_rows_q);
			REG_A_COLS: prdata = 32'(a_cols_q);
			REG_B_ROWS: prdata = 32'(b_rows_q);
			REG_B_COLS: prdata = 32'(b_cols_q);
			default:    prdata = '0;
		endcase
	end

	// Out-of-range dimension values are clamped into 1..MAX_DIM here, so
	// both halves see only meaningful sizes.
	assign dims.a_rows = eff_dim(a_rows_q, MAX_DIM);
	assign dims.a_cols = eff_dim(a_cols_q, MAX_DIM);
	assign dims.b_rows = eff_dim(b_rows_q, MAX_DIM);
	assign dims.b_cols = eff_dim(b_cols_q, MAX_DIM);

	mme_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_opcode (s_axis_tuser),
		.in_row    (s_axis_tdata[2:0]),
		.in_col    (s_axis_tdata[5:3]),
		.in_value  (s_axis_tdata[37:6]),
		.dims      (dims),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	mme_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.dims       (dims),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_row    (res_row),
		.out_col    (res_col),
		.out_value  (res_value),
		.out_status (res_status),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, res_value, res_col, res_row};
	assign m_axis_tuser = res_status;

	// A refused write is always a lone acknowledgment with a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[37:6] == '0 && m_axis_tlast)
		else $error("refused write result carries a value or lacks tlast");

	// The back end only takes a command that the queue holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command taken from an empty queue");

	// The queue can only fill up through an accepted item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(s_axis_tvalid))
		else $error("input ready dropped without an accepted item");

endmodule

@@ bench/tb_matrix_multiply_engine.sv @@
// ----------------------------------------------------------------------------
// tb_matrix_multiply_engine
// Self-checking bench for the Q16.16 matrix multiply engine.
// ----------------------------------------------------------------------------
// Element writes and compute commands go in on s_axis. A local model of both
// element stores and the dimension registers predicts every acknowledgment
// and product entry, and the results on m_axis are checked against it in
// order. A directed opening covers saturation, floor rounding, refused writes
// and clamped dimensions, then random phases load and multiply matrices of
// many shapes while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_engine
	import mme_pkg::*;
();

	localparam int MAX_DIM        = MAX_DIM_DEF;
	localparam int ITEM_TARGET    = 440;   // directed opening plus about 420 random
	localparam int SETTLE_CYCLES  = 16;    // covers an ignored item still in flight
	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 4000;

	// The fourth opcode is unused and the engine drops it without a result.
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	// Saturation bounds of a product entry after the shift to Q16.16.
	localparam logic signed [71:0] Q_MAX = 72'sh7FFF_FFFF;
	localparam logic signed [71:0] Q_MIN = -72'sh8000_0000;

	typedef struct {
		logic [OPCODE_W-1:0] opcode;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
		logic [VALUE_W-1:0]  value;
	} cmd_item_t;

	typedef struct {
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [VALUE_W-1:0] value;
		logic               status;
		logic               last;
	} entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // row[2:0], col[5:3], value[37:6], zero pad
	logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // out_row[2:0], out_col[5:3], out_value[37:6], zero pad
	logic [0:0]  m_axis_tuser;        // status[0]
	logic        m_axis_tlast;

	matrix_multiply_engine #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #1 clk = ~clk;

	// Commands waiting to be sent, and the entries the engine still owes us.
	cmd_item_t cmd_q[$];
	entry_t    entry_q[$];

	// Bench copy of the engine state: raw register values and both stores.
	logic [DIM_W-1:0]   dim_reg [4];
	logic [VALUE_W-1:0] left_mem [MAX_DIM*MAX_DIM];
	logic [VALUE_W-1:0] right_mem [MAX_DIM*MAX_DIM];

	int mismatch_cnt = 0;
	int stim_count = 0;
	int hold_req = 0;

	// A dimension register of zero behaves as one, anything above the
	// largest size behaves as the largest size.
	function automatic int dim_used(input logic [DIM_W-1:0] r);
		if (r == '0) begin
			return 1;
		end
		if (r > MAX_DIM) begin
			return MAX_DIM;
		end
		return int'(r);
	endfunction

	// Mostly values within +-4.0 so that sums stay in range, sometimes the
	// full 32-bit range or an extreme so that saturation shows up too.
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: begin
				return $urandom();
			end
			1: begin
				return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			end
			default: begin
				return 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
			end
		endcase
	endfunction

	// Any opcode, the unused one included; writes dominate.
	function automatic logic [OPCODE_W-1:0] OP_OPCODE_RANDOM();
		case ($urandom_range(0, 5))
			0, 1: return OP_WRITE_A;
			2, 3: return OP_WRITE_B;
			4: return OP_COMPUTE;
			default: return OP_UNUSED;
		endcase
	endfunction

	// Works out what one accepted command produces and updates the stores.
	task automatic apply_command(input cmd_item_t cmd);
		int ar, ac, br, bc, terms;
		logic signed [VALUE_W-1:0] lhs, rhs;
		logic signed [71:0] prod, acc, scaled;
		bit in_range;
		entry_t ent;
		ar = dim_used(dim_reg[REG_A_ROWS]);
		ac = dim_used(dim_reg[REG_A_COLS]);
		br = dim_used(dim_reg[REG_B_ROWS]);
		bc = dim_used(dim_reg[REG_B_COLS]);
		case (cmd.opcode)
			OP_WRITE_A, OP_WRITE_B: begin
				if (cmd.opcode == OP_WRITE_A) begin
					in_range = (cmd.row < ar) && (cmd.col < ac);
					if (in_range) begin
						left_mem[{cmd.row, cmd.col}] = cmd.value;
					end
				end else begin
					in_range = (cmd.row < br) && (cmd.col < bc);
					if (in_range) begin
						right_mem[{cmd.row, cmd.col}] = cmd.value;
					end
				end
				ent.row = cmd.row;
				ent.col = cmd.col;
				ent.value = '0;
				ent.status = in_range ? STATUS_OK : STATUS_RANGE;
				ent.last = 1'b1;
				entry_q.push_back(ent);
			end
			OP_COMPUTE: begin
				terms = (ac < br) ? ac : br;
				for (int i = 0; i < ar; i++) begin
					for (int j = 0; j < bc; j++) begin
						// Exact sum of full products, floored to Q16.16.
						acc = '0;
						for (int k = 0; k < terms; k++) begin
							lhs = left_mem[i*MAX_DIM + k];
							rhs = right_mem[k*MAX_DIM + j];
							prod = lhs * rhs;
							acc += prod;
						end
						scaled = acc >>> FRAC_W;
						if (scaled > Q_MAX) begin
							ent.value = 32'h7FFF_FFFF;
						end else if (scaled < Q_MIN) begin
							ent.value = 32'h8000_0000;
						end else begin
							ent.value = scaled[VALUE_W-1:0];
						end
						ent.row = ROW_W'(i);
						ent.col = COL_W'(j);
						ent.status = STATUS_OK;
						ent.last = (i == ar - 1) && (j == bc - 1);
						entry_q.push_back(ent);
					end
				end
			end
			default: begin
				// The unused opcode produces nothing.
			end
		endcase
	endtask

	task automatic push_cmd(input logic [OPCODE_W-1:0] op, input int r, input int c,
			input logic [VALUE_W-1:0] v);
		cmd_q.push_back('{opcode: op, row: ROW_W'(r), col: COL_W'(c), value: v});
		if (op != OP_UNUSED) begin
			stim_count++;
		end
	endtask

	// Waits until every command has gone in and every entry has come out,
	// then a little longer for a dropped item that may still be in flight.
	task automatic wait_drained();
		while (cmd_q.size() != 0 || entry_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB write: setup cycle, then access until pready. The upper bits
	// of pwdata carry junk, since only the low four bits belong to a register.
	task automatic apb_write(input logic [1:0] idx, input logic [DIM_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {28'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		dim_reg[idx] = val;
	endtask

	task automatic program_dims(input logic [DIM_W-1:0] a_r, input logic [DIM_W-1:0] a_c,
			input logic [DIM_W-1:0] b_r, input logic [DIM_W-1:0] b_c);
		wait_drained();
		apb_write(REG_A_ROWS, a_r);
		apb_write(REG_A_COLS, a_c);
		apb_write(REG_B_ROWS, b_r);
		apb_write(REG_B_COLS, b_c);
	endtask

	// Sender: bursts of random length separated by random gaps. A gap of
	// zero length lets consecutive bursts run together without idling. The
	// prediction is made at the edge where the item is taken.
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_command(cmd_q.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// The offered item stays on the bus until it is taken.
			end else if (gap_left > 0 || cmd_q.size() == 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {2'b00, cmd_q[0].value, cmd_q[0].col, cmd_q[0].row};
				s_axis_tuser <= cmd_q[0].opcode;
			end
		end
	end

	// Receiver: checks each result against the oldest expected entry and
	// drives tready from a rotating stall pattern, redrawn when its counter
	// runs out. A request from the stimulus process starts a long hold-off.
	entry_t      want, got;
	logic [15:0] ready_pattern = 16'hFFFF;
	int          pattern_left = 0;
	int          hold_left = 0;
	int          hold_done = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.row = m_axis_tdata[2:0];
				got.col = m_axis_tdata[5:3];
				got.value = m_axis_tdata[37:6];
				got.status = m_axis_tuser[0];
				got.last = m_axis_tlast;
				if (entry_q.size() == 0) begin
					$display("%0t: result with nothing expected: row %0d col %0d value %h status %b last %b",
						$time, got.row, got.col, got.value, got.status, got.last);
					mismatch_cnt++;
				end else begin
					want = entry_q.pop_front();
					if (got.row !== want.row || got.col !== want.col ||
							got.value !== want.value || got.status !== want.status ||
							got.last !== want.last) begin
						$display("%0t: mismatch, expected row %0d col %0d value %h status %b last %b",
							$time, want.row, want.col, want.value, want.status, want.last);
						$display("%0t:           actual row %0d col %0d value %h status %b last %b",
							$time, got.row, got.col, got.value, got.status, got.last);
						mismatch_cnt++;
					end
				end
			end
			if (hold_done != hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_done = hold_req;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					case ($urandom_range(0, 3))
						0: ready_pattern = 16'hFFFF;
						1: ready_pattern = 16'($urandom());
						2: ready_pattern = 16'($urandom() | $urandom());
						default: ready_pattern = 16'($urandom() & $urandom());
					endcase
					if (ready_pattern == '0) begin
						ready_pattern = 16'h0001;
					end
					pattern_left = 48;
				end
				pattern_left--;
				m_axis_tready <= ready_pattern[0];
				ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
			end
		end
	end

	// Watchdog: a stretch with no item taken on either side means a hang.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Stimulus: directed opening, then random phases until enough items.
	initial begin
		int phase;
		int ar, ac, br, bc, reps;
		logic [DIM_W-1:0] set_dims [4];

		foreach (dim_reg[i]) begin
			dim_reg[i] = 4'd1;
		end
		foreach (left_mem[i]) begin
			left_mem[i] = '0;
			right_mem[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset dimensions, every matrix is 1x1. Cleared stores give zero,
		// then the largest operands saturate high and low, writes outside
		// the matrix are refused, the unused opcode is dropped, and a tiny
		// negative product floors to minus one LSB.
		push_cmd(OP_COMPUTE, 0, 0, 32'h0);
		push_cmd(OP_WRITE_A, 0, 0, 32'h7FFF_FFFF);
		push_cmd(OP_WRITE_B, 0, 0, 32'h7FFF_FFFF);
		push_cmd(OP_COMPUTE, 7, 7, 32'hFFFF_FFFF);
		push_cmd(OP_WRITE_B, 0, 0, 32'h8000_0000);
		push_cmd(OP_COMPUTE, 3, 5, $urandom());
		push_cmd(OP_WRITE_A, 1, 0, 32'h1234_5678);
		push_cmd(OP_WRITE_A, 0, 7, 32'hFFFF_FFFF);
		push_cmd(OP_WRITE_B, 7, 7, 32'h0001_0000);
		push_cmd(OP_UNUSED, 7, 7, $urandom());
		push_cmd(OP_WRITE_A, 0, 0, 32'hFFFF_FFFF);
		push_cmd(OP_WRITE_B, 0, 0, 32'h0000_0001);
		push_cmd(OP_COMPUTE, 0, 0, 32'h0);

		// Out-of-range register values: zero acts as one, anything above
		// eight as eight, giving a 1x8 by 8x1 product with eight terms.
		program_dims(4'd0, 4'd15, 4'd9, 4'd0);
		push_cmd(OP_WRITE_A, 0, 7, 32'h0001_0000);
		push_cmd(OP_WRITE_B, 7, 0, 32'hFFFF_8000);
		push_cmd(OP_WRITE_A, 1, 0, 32'h7FFF_FFFF);
		push_cmd(OP_WRITE_B, 0, 1, 32'h7FFF_FFFF);
		push_cmd(OP_COMPUTE, 0, 0, 32'h0);

		// Random phases. The first few use fixed extreme shapes; the first of
		// all is the full 8x8 case, run while the receiver holds off for a
		// long time so that the engine backs up and stalls its input.
		phase = 0;
		while (stim_count < ITEM_TARGET) begin
			case (phase)
				0: set_dims = '{4'd8, 4'd8, 4'd8, 4'd8};
				1: set_dims = '{4'd1, 4'd1, 4'd1, 4'd1};
				2: set_dims = '{4'd15, 4'd0, 4'd9, 4'd3};
				default: begin
					foreach (set_dims[i]) begin
						if ($urandom_range(0, 7) == 0) begin
							set_dims[i] = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
						end else if ($urandom_range(0, 9) == 0) begin
							set_dims[i] = 4'($urandom_range(5, 8));
						end else begin
							set_dims[i] = 4'($urandom_range(1, 4));
						end
					end
				end
			endcase
			program_dims(set_dims[0], set_dims[1], set_dims[2], set_dims[3]);
			if (phase == 0) begin
				hold_req++;
			end
			ar = dim_used(dim_reg[REG_A_ROWS]);
			ac = dim_used(dim_reg[REG_A_COLS]);
			br = dim_used(dim_reg[REG_B_ROWS]);
			bc = dim_used(dim_reg[REG_B_COLS]);
			reps = (ar * ac + br * bc > 32) ? 1 : $urandom_range(1, 3);
			repeat (reps) begin
				// Load a random subset of both matrices, with now and then a
				// stray item of any kind, then multiply.
				for (int r = 0; r < ar; r++) begin
					for (int c = 0; c < ac; c++) begin
						if ($urandom_range(0, 3) != 0) begin
							push_cmd(OP_WRITE_A, r, c, pick_value());
						end
						if ($urandom_range(0, 11) == 0) begin
							push_cmd(OP_OPCODE_RANDOM(), $urandom_range(0, 7),
								$urandom_range(0, 7), $urandom());
						end
					end
				end
				for (int r = 0; r < br; r++) begin
					for (int c = 0; c < bc; c++) begin
						if ($urandom_range(0, 3) != 0) begin
							push_cmd(OP_WRITE_B, r, c, pick_value());
						end
						if ($urandom_range(0, 11) == 0) begin
							push_cmd(OP_OPCODE_RANDOM(), $urandom_range(0, 7),
								$urandom_range(0, 7), $urandom());
						end
					end
				end
				push_cmd(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
			end
			phase++;
		end

		wait_drained();
		if (mismatch_cnt == 0 && entry_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/mme_pkg.sv
hw/rtl/mme_ram.sv
hw/rtl/mme_front.sv
hw/rtl/mme_back.sv
hw/rtl/matrix_multiply_engine.sv
bench/tb_matrix_multiply_engine.sv
